// File: rtl/core/lzss_pkg.sv
`timescale 1ns / 1ps

package lzss_pkg;

    localparam int LZSS_WINDOW        = 2048;
    localparam int LZSS_OFFSET_WIDTH  = 11;
    localparam int LZSS_LENGTH_WIDTH  = 4;
    localparam int LZSS_LITERAL_LIMIT = 1;
    localparam int LZSS_LOOKAHEAD     = 17;

    localparam logic [7:0] SPACE_BYTE = 8'h20;

    // Request from the sequencer to the bit packer.
    typedef struct packed {
        logic valid;
        logic flush;
        logic bit_val;
        logic last_mode;
    } t_pack_cmd;

endpackage

// File: rtl/core/lzss_stream_if.sv
`timescale 1ns / 1ps

interface lzss_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       last_byte;

    modport source(output valid, output in_byte, output last_byte, input ready);
    modport sink(input valid, input in_byte, input last_byte, output ready);
endinterface

interface lzss_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_out;

    modport source(output valid, output out_byte, output last_out, input ready);
    modport sink(input valid, input out_byte, input last_out, output ready);
endinterface

// File: rtl/core/lzss_ram.sv
`timescale 1ns / 1ps

module lzss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

// File: rtl/core/lzss_pack.sv
`timescale 1ns / 1ps

module lzss_pack (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lzss_pkg::t_pack_cmd i_cmd,
    output logic               o_ack,
    lzss_out_if.source         o_out
);

    import lzss_pkg::*;

    logic [7:0] r_acc, n_acc;
    logic [2:0] r_pend, n_pend;
    logic [7:0] r_hold, n_hold;
    logic       r_hold_v, n_hold_v;
    logic       r_ov;
    logic [7:0] r_ob;
    logic       r_ol;

    logic       can_push;
    logic       push;
    logic [7:0] push_byte;
    logic       push_last;
    logic [7:0] full_acc;
    logic [7:0] pad;

    assign can_push = !r_ov || o_out.ready;
    assign full_acc = {r_acc[6:0], i_cmd.bit_val};
    assign pad      = r_acc << (4'd8 - {1'b0, r_pend});

    always_comb begin
        n_acc     = r_acc;
        n_pend    = r_pend;
        n_hold    = r_hold;
        n_hold_v  = r_hold_v;
        push      = 1'b0;
        push_byte = r_hold;
        push_last = 1'b0;
        o_ack     = 1'b0;
        if (i_cmd.valid && !i_cmd.flush) begin
            if (r_pend != 3'd7) begin
                o_ack  = 1'b1;
                n_acc  = full_acc;
                n_pend = r_pend + 3'd1;
            end else if (i_cmd.last_mode) begin
                // In the final transaction of a stream a full byte is held back
                // until it is known whether it is the final output byte.
                if (!r_hold_v || can_push) begin
                    push     = r_hold_v;
                    n_hold   = full_acc;
                    n_hold_v = 1'b1;
                    o_ack    = 1'b1;
                    n_acc    = '0;
                    n_pend   = '0;
                end
            end else if (can_push) begin
                push      = 1'b1;
                push_byte = full_acc;
                o_ack     = 1'b1;
                n_acc     = '0;
                n_pend    = '0;
            end
        end else if (i_cmd.valid) begin
            if (r_pend != 3'd0) begin
                if (r_hold_v) begin
                    if (can_push) begin
                        push     = 1'b1;
                        n_hold_v = 1'b0;
                    end
                end else if (can_push) begin
                    push      = 1'b1;
                    push_byte = pad;
                    push_last = 1'b1;
                    o_ack     = 1'b1;
                    n_acc     = '0;
                    n_pend    = '0;
                end
            end else if (r_hold_v) begin
                if (can_push) begin
                    push      = 1'b1;
                    push_last = 1'b1;
                    n_hold_v  = 1'b0;
                    o_ack     = 1'b1;
                end
            end else begin
                o_ack = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= '0;
            r_pend   <= '0;
            r_hold_v <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_acc    <= n_acc;
            r_pend   <= n_pend;
            r_hold_v <= n_hold_v;
            if (push) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_hold <= n_hold;
        if (push) begin
            r_ob <= push_byte;
            r_ol <= push_last;
        end
    end

    assign o_out.valid    = r_ov;
    assign o_out.out_byte = r_ob;
    assign o_out.last_out = r_ol;

endmodule

// File: rtl/core/lzss_stream_encoder.sv
`timescale 1ns / 1ps
// A byte that leaves the lookahead short of full is taken while the encoder stays idle.
// A token search reads each compared byte in S_ISSUE and checks it in S_CMP, over up to
// WINDOW - LOOKAHEAD history distances; S_DECIDE then picks the token and S_SHIFT hands it to the packer bit by bit.
// Throughput: a search codes one to LEN_CAP bytes and frees that many lookahead slots,
// so that many input bytes are taken per search; output stalls stretch the search.
// Reset is synchronous and active low; a fill count makes unwritten history read as spaces.

module lzss_stream_encoder #(
    parameter int WINDOW        = lzss_pkg::LZSS_WINDOW,
    parameter int OFFSET_WIDTH  = lzss_pkg::LZSS_OFFSET_WIDTH,
    parameter int LENGTH_WIDTH  = lzss_pkg::LZSS_LENGTH_WIDTH,
    parameter int LITERAL_LIMIT = lzss_pkg::LZSS_LITERAL_LIMIT,
    parameter int LOOKAHEAD     = lzss_pkg::LZSS_LOOKAHEAD
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lzss_in_if.sink     i_in,
    lzss_out_if.source  o_out
);

    import lzss_pkg::*;

    localparam int AW       = $clog2(WINDOW);
    localparam int HS       = (WINDOW > LOOKAHEAD) ? (WINDOW - LOOKAHEAD) : 0;
    localparam int CODE_CAP = (1 << LENGTH_WIDTH) - 1 + LITERAL_LIMIT + 1;
    localparam int LEN_CAP  = (CODE_CAP < LOOKAHEAD) ? CODE_CAP : LOOKAHEAD;
    localparam int TRIG     = (LOOKAHEAD < WINDOW) ? LOOKAHEAD : WINDOW;
    localparam int NMAX     = (TRIG > LEN_CAP) ? TRIG : LEN_CAP;
    localparam int NW       = $clog2(NMAX + 1);
    localparam int DW       = $clog2(HS + 2);
    localparam int FW       = $clog2(WINDOW + 1);
    localparam int TW       = 1 + OFFSET_WIDTH + LENGTH_WIDTH;
    localparam int SW       = (TW > 9) ? TW : 9;
    localparam int BW       = $clog2(SW + 1);
    localparam int PW       = (OFFSET_WIDTH > AW) ? OFFSET_WIDTH : AW;
    localparam logic [AW-1:0] CP_RST = AW'(HS % WINDOW);
    localparam logic [AW:0]   HS_A   = (AW + 1)'(HS);
    localparam logic [AW:0]   W_A    = (AW + 1)'(WINDOW);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_START  = 4'd1;
    localparam logic [3:0] S_ISSUE  = 4'd2;
    localparam logic [3:0] S_CMP    = 4'd3;
    localparam logic [3:0] S_DECIDE = 4'd4;
    localparam logic [3:0] S_LREAD  = 4'd5;
    localparam logic [3:0] S_LDATA  = 4'd6;
    localparam logic [3:0] S_SHIFT  = 4'd7;
    localparam logic [3:0] S_NEXT   = 4'd8;
    localparam logic [3:0] S_FLUSH  = 4'd9;

    function automatic logic [AW-1:0] f_inc(input logic [AW-1:0] a);
        f_inc = (a == AW'(WINDOW - 1)) ? '0 : a + 1'b1;
    endfunction

    function automatic logic [AW-1:0] f_addmod(input logic [AW-1:0] a, input logic [NW-1:0] n);
        logic [AW:0] s;
        s = (AW + 1)'(a) + (AW + 1)'(n);
        f_addmod = (s >= W_A) ? AW'(s - W_A) : AW'(s);
    endfunction

    function automatic logic f_written(input logic [AW-1:0] a, input logic [FW-1:0] fill);
        logic [AW:0] off;
        off = ({1'b0, a} >= HS_A) ? ({1'b0, a} - HS_A) : ({1'b0, a} + W_A - HS_A);
        f_written = off < (AW + 1)'(fill);
    endfunction

    logic [3:0]    r_state, n_state;
    logic [AW-1:0] r_cp, n_cp;
    logic [NW-1:0] r_cnt, n_cnt;
    logic [FW-1:0] r_fill, n_fill;
    logic          r_last, n_last;
    logic [NW-1:0] r_maxlen, n_maxlen;
    logic [NW-1:0] r_best, n_best;
    logic [NW-1:0] r_j, n_j;
    logic [DW-1:0] r_d, n_d;
    logic [AW-1:0] r_cand, n_cand;
    logic [AW-1:0] r_bpos, n_bpos;
    logic [AW-1:0] r_pa, n_pa;
    logic [AW-1:0] r_pb, n_pb;
    logic          r_va, r_vb;
    logic [SW-1:0] r_sr, n_sr;
    logic [BW-1:0] r_nb, n_nb;
    logic          r_lit, n_lit;

    logic          accept;
    logic [NW-1:0] cnt_inc;
    logic [NW-1:0] len_now;
    logic [AW-1:0] wr_addr;
    logic [7:0]    rd_a, rd_b;
    logic [7:0]    byte_a, byte_b;
    logic          eq;
    logic [NW-1:0] jn;
    logic [PW-1:0] pos_w;
    logic [NW-1:0] len_diff;
    logic [TW-1:0] tok;
    t_pack_cmd     s_cmd;
    logic          pack_ack;

    assign i_in.ready = (r_state == S_IDLE);
    assign accept     = i_in.valid && i_in.ready;
    assign cnt_inc    = r_cnt + 1'b1;
    assign wr_addr    = f_addmod(r_cp, r_cnt);
    assign len_now    = (r_cnt < NW'(LEN_CAP)) ? r_cnt : NW'(LEN_CAP);
    assign byte_a     = r_va ? rd_a : SPACE_BYTE;
    assign byte_b     = r_vb ? rd_b : SPACE_BYTE;
    assign eq         = (byte_a == byte_b);
    assign jn         = eq ? r_j + 1'b1 : r_j;
    assign pos_w      = PW'(r_bpos);
    assign len_diff   = r_best - NW'(LITERAL_LIMIT + 1);
    assign tok        = {1'b0, pos_w[OFFSET_WIDTH-1:0], LENGTH_WIDTH'(len_diff)};

    assign s_cmd.valid     = (r_state == S_SHIFT) || (r_state == S_FLUSH);
    assign s_cmd.flush     = (r_state == S_FLUSH);
    assign s_cmd.bit_val   = r_sr[SW-1];
    assign s_cmd.last_mode = r_last;

    lzss_ram #(
        .WIDTH(8),
        .DEPTH(WINDOW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (accept),
        .i_waddr   (wr_addr),
        .i_wdata   (i_in.in_byte),
        .i_raddr_a (r_pa),
        .i_raddr_b (r_pb),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    lzss_pack u_pack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (s_cmd),
        .o_ack   (pack_ack),
        .o_out   (o_out)
    );

    always_comb begin
        n_state  = r_state;
        n_cp     = r_cp;
        n_cnt    = r_cnt;
        n_fill   = r_fill;
        n_last   = r_last;
        n_maxlen = r_maxlen;
        n_best   = r_best;
        n_j      = r_j;
        n_d      = r_d;
        n_cand   = r_cand;
        n_bpos   = r_bpos;
        n_pa     = r_pa;
        n_pb     = r_pb;
        n_sr     = r_sr;
        n_nb     = r_nb;
        n_lit    = r_lit;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cnt  = cnt_inc;
                    n_fill = (r_fill == FW'(WINDOW)) ? r_fill : r_fill + 1'b1;
                    n_last = i_in.last_byte;
                    if (i_in.last_byte || cnt_inc >= NW'(TRIG)) begin
                        n_state = S_START;
                    end
                end
            end
            S_START: begin
                n_maxlen = len_now;
                n_best   = NW'(1);
                n_j      = '0;
                n_d      = DW'(1);
                n_cand   = (r_cp == '0) ? AW'(WINDOW - 1) : r_cp - 1'b1;
                n_pa     = n_cand;
                n_pb     = r_cp;
                if (HS == 0 || len_now <= NW'(1)) begin
                    n_state = S_DECIDE;
                end else begin
                    n_state = S_ISSUE;
                end
            end
            S_ISSUE: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (eq && jn < r_maxlen) begin
                    n_j     = jn;
                    n_pa    = f_inc(r_pa);
                    n_pb    = f_inc(r_pb);
                    n_state = S_ISSUE;
                end else begin
                    if (jn > r_best) begin
                        n_best = jn;
                        n_bpos = r_cand;
                    end
                    if (jn == r_maxlen || r_d == DW'(HS)) begin
                        n_state = S_DECIDE;
                    end else begin
                        n_d     = r_d + 1'b1;
                        n_cand  = (r_cand == '0) ? AW'(WINDOW - 1) : r_cand - 1'b1;
                        n_pa    = n_cand;
                        n_pb    = r_cp;
                        n_j     = '0;
                        n_state = S_ISSUE;
                    end
                end
            end
            S_DECIDE: begin
                if (r_best <= NW'(LITERAL_LIMIT)) begin
                    n_j     = '0;
                    n_pb    = r_cp;
                    n_state = S_LREAD;
                end else begin
                    n_sr    = SW'(tok) << (SW - TW);
                    n_nb    = BW'(TW);
                    n_lit   = 1'b0;
                    n_state = S_SHIFT;
                end
            end
            S_LREAD: begin
                n_state = S_LDATA;
            end
            S_LDATA: begin
                n_sr    = SW'({1'b1, byte_b}) << (SW - 9);
                n_nb    = BW'(9);
                n_lit   = 1'b1;
                n_state = S_SHIFT;
            end
            S_SHIFT: begin
                if (pack_ack) begin
                    n_sr = r_sr << 1;
                    n_nb = r_nb - 1'b1;
                    if (r_nb == BW'(1)) begin
                        if (r_lit && (r_j + 1'b1) < r_best) begin
                            n_j     = r_j + 1'b1;
                            n_pb    = f_inc(r_pb);
                            n_state = S_LREAD;
                        end else begin
                            n_state = S_NEXT;
                        end
                    end
                end
            end
            S_NEXT: begin
                n_cp  = f_addmod(r_cp, r_best);
                n_cnt = r_cnt - r_best;
                if (!r_last) begin
                    n_state = S_IDLE;
                end else if (r_cnt == r_best) begin
                    n_state = S_FLUSH;
                end else begin
                    n_state = S_START;
                end
            end
            S_FLUSH: begin
                if (pack_ack) begin
                    n_cp    = CP_RST;
                    n_cnt   = '0;
                    n_fill  = '0;
                    n_last  = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cp    <= CP_RST;
            r_cnt   <= '0;
            r_fill  <= '0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cp    <= n_cp;
            r_cnt   <= n_cnt;
            r_fill  <= n_fill;
            r_last  <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_maxlen <= n_maxlen;
        r_best   <= n_best;
        r_j      <= n_j;
        r_d      <= n_d;
        r_cand   <= n_cand;
        r_bpos   <= n_bpos;
        r_pa     <= n_pa;
        r_pb     <= n_pb;
        r_va     <= f_written(r_pa, r_fill);
        r_vb     <= f_written(r_pb, r_fill);
        r_sr     <= n_sr;
        r_nb     <= n_nb;
        r_lit    <= n_lit;
    end

endmodule

// File: rtl/core/lzss_enc_chk.sv
`timescale 1ns / 1ps

module lzss_enc_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_in_last,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_out_last
);

    // A stalled output transaction stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output valid dropped while stalled");

    // A stalled output transaction keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_byte) && $stable(i_out_last))
        else $error("output payload changed while stalled");

    // The final input byte of a stream always starts a drain.
    a_last_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_last |=> !i_in_ready)
        else $error("encoder ready right after the final input byte");

    // Output bytes are only produced while the encoder is busy coding.
    a_out_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(i_in_ready))
        else $error("output produced while the encoder was idle");

endmodule

bind lzss_stream_encoder lzss_enc_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_last   (i_in.last_byte),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.out_byte),
    .i_out_last  (o_out.last_out)
);

// File: bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import lzss_pkg::*;

    localparam int WIN      = LZSS_WINDOW;
    localparam int AHEAD    = LZSS_LOOKAHEAD;
    localparam int SPAN     = (WIN > AHEAD) ? (WIN - AHEAD) : 0;
    localparam int CODE_CAP = (1 << LZSS_LENGTH_WIDTH) - 1 + LZSS_LITERAL_LIMIT + 1;
    localparam int LEN_CAP  = (CODE_CAP < AHEAD) ? CODE_CAP : AHEAD;
    localparam int N_ITEMS  = 290;
    localparam int WDOG_LIMIT = 200000;
    localparam int HOLD_CYCLES = 20000;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_packed_byte;

    typedef struct {
        logic [7:0] data;
        logic       last;
        int         n_typed;
        logic [7:0] t0;
        logic [7:0] t1;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    lzss_in_if  in_if();
    lzss_out_if out_if();

    lzss_stream_encoder dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Predictor state.
    logic [7:0]   win_mem[WIN];
    int           code_pos;
    int           ahead_cnt;
    logic [7:0]   bit_acc;
    int           bit_cnt;
    t_packed_byte pending_bytes[$];
    t_packed_byte expected_bytes[$];

    int  errors = 0;
    int  items_sent = 0;
    int  streams_sent = 0;
    int  bytes_checked = 0;
    int  matches_seen = 0;
    bit  stim_done = 1'b0;
    bit  held_off = 1'b0;

    function automatic void encoder_reset();
        for (int k = 0; k < WIN; k++) win_mem[k] = SPACE_BYTE;
        code_pos  = SPAN % WIN;
        ahead_cnt = 0;
        bit_acc   = 8'h00;
        bit_cnt   = 0;
    endfunction

    function automatic void push_bit(logic b);
        t_packed_byte pb;
        bit_acc = {bit_acc[6:0], b};
        bit_cnt++;
        if (bit_cnt == 8) begin
            pb.data = bit_acc;
            pb.last = 1'b0;
            pending_bytes.push_back(pb);
            bit_acc = 8'h00;
            bit_cnt = 0;
        end
    endfunction

    function automatic void push_field(int value, int width);
        for (int k = width - 1; k >= 0; k--) push_bit(1'((value >> k) & 1));
    endfunction

    function automatic void code_one_token();
        int r, maxl, best, best_pos, i, j;
        r = code_pos % WIN;
        maxl = (ahead_cnt < LEN_CAP) ? ahead_cnt : LEN_CAP;
        best = 1;
        best_pos = 0;
        for (int d = 1; d <= SPAN; d++) begin
            i = (r + WIN - d) % WIN;
            j = 0;
            while (j < maxl && win_mem[(i + j) % WIN] == win_mem[(r + j) % WIN]) j++;
            if (j > best) begin
                best = j;
                best_pos = i;
            end
        end
        if (best > ahead_cnt) best = ahead_cnt;
        if (best == 0) return;
        if (best <= LZSS_LITERAL_LIMIT) begin
            for (int k = 0; k < best; k++) begin
                push_bit(1'b1);
                push_field(int'(win_mem[(r + k) % WIN]), 8);
            end
        end else begin
            matches_seen++;
            push_bit(1'b0);
            push_field(best_pos & ((1 << LZSS_OFFSET_WIDTH) - 1), LZSS_OFFSET_WIDTH);
            push_field(best - (LZSS_LITERAL_LIMIT + 1), LZSS_LENGTH_WIDTH);
        end
        code_pos = (r + best) % WIN;
        ahead_cnt -= best;
    endfunction

    function automatic void encode_byte(logic [7:0] data, logic last);
        t_packed_byte pb;
        pending_bytes.delete();
        win_mem[(code_pos + ahead_cnt) % WIN] = data;
        ahead_cnt++;
        if (last) begin
            while (ahead_cnt > 0) code_one_token();
            if (bit_cnt != 0) begin
                pb.data = bit_acc << (8 - bit_cnt);
                pb.last = 1'b0;
                pending_bytes.push_back(pb);
            end
            if (pending_bytes.size() > 0)
                pending_bytes[pending_bytes.size() - 1].last = 1'b1;
            encoder_reset();
        end else if (ahead_cnt >= AHEAD || ahead_cnt >= WIN) begin
            code_one_token();
        end
    endfunction

    // Sends one item and updates the prediction when the transaction completes.
    task automatic send_byte(logic [7:0] data, logic last, int n_typed,
                             logic [7:0] t0, logic [7:0] t1);
        t_packed_byte pb;
        while (!(items_sent >= 150 && items_sent < 200) && $urandom_range(99) < 14) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.in_byte   <= data;
        in_if.last_byte <= last;
        do @(posedge i_clk); while (!in_if.ready);
        encode_byte(data, last);
        if (n_typed > 0) begin
            pb.data = t0;
            pb.last = (n_typed == 1);
            expected_bytes.push_back(pb);
            if (n_typed > 1) begin
                pb.data = t1;
                pb.last = 1'b1;
                expected_bytes.push_back(pb);
            end
        end else begin
            foreach (pending_bytes[k]) expected_bytes.push_back(pending_bytes[k]);
        end
        items_sent++;
        if (last) streams_sent++;
    endtask

    t_stim_row directed_rows[$];

    initial begin
        int         mode, len, period;
        logic [7:0] alpha[4];
        logic [7:0] pattern[8];
        logic [7:0] b;
        logic       lst;
        t_stim_row  row;

        in_if.valid     <= 1'b0;
        in_if.in_byte   <= 8'h00;
        in_if.last_byte <= 1'b0;
        encoder_reset();

        directed_rows.push_back('{8'h41, 1'b1, 2, 8'hA0, 8'h80});
        directed_rows.push_back('{SPACE_BYTE, 1'b1, 2, 8'h90, 8'h00});
        directed_rows.push_back('{8'h00, 1'b0, 0, 8'h00, 8'h00});
        directed_rows.push_back('{8'hFF, 1'b1, 0, 8'h00, 8'h00});
        for (int k = 0; k < 18; k++)
            directed_rows.push_back('{SPACE_BYTE, k == 17, 0, 8'h00, 8'h00});

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k]) begin
            row = directed_rows[k];
            send_byte(row.data, row.last, row.n_typed, row.t0, row.t1);
        end

        // Random streams: mostly repetitive content so that matches occur.
        while (items_sent < N_ITEMS) begin
            mode = $urandom_range(3);
            len = $urandom_range(1, 30);
            period = $urandom_range(1, 8);
            foreach (alpha[k]) alpha[k] = 8'($urandom);
            foreach (pattern[k]) pattern[k] = 8'($urandom);
            for (int k = 0; k < len && items_sent < N_ITEMS; k++) begin
                case (mode)
                    0: b = 8'($urandom);
                    1: b = alpha[$urandom_range(3)];
                    2: b = pattern[k % period];
                    default: b = ($urandom_range(3) == 0) ? SPACE_BYTE : alpha[0];
                endcase
                lst = (k == len - 1) || (items_sent == N_ITEMS - 1);
                send_byte(b, lst, 0, 8'h00, 8'h00);
                if (lst) break;
            end
        end
        in_if.valid <= 1'b0;
        stim_done = 1'b1;
    end

    // Receiver: random stalls, one long hold-off, and a stretch without stalls.
    initial begin
        out_if.ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (!held_off && bytes_checked >= 30) begin
                held_off = 1'b1;
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                out_if.ready <= 1'b1;
                @(posedge i_clk);
            end else if (bytes_checked >= 60 && bytes_checked < 110) begin
                out_if.ready <= 1'b1;
            end else begin
                out_if.ready <= ($urandom_range(99) >= 14);
            end
        end
    end

    always @(posedge i_clk) begin
        t_packed_byte exp_b;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_bytes.size() == 0) begin
                $error("unexpected output byte %h last %b", out_if.out_byte, out_if.last_out);
                errors++;
            end else begin
                exp_b = expected_bytes.pop_front();
                if (out_if.out_byte !== exp_b.data) begin
                    $error("out_byte expected %h actual %h", exp_b.data, out_if.out_byte);
                    errors++;
                end
                if (out_if.last_out !== exp_b.last) begin
                    $error("last_out expected %b actual %b", exp_b.last, out_if.last_out);
                    errors++;
                end
            end
            bytes_checked++;
        end
    end

    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WDOG_LIMIT) begin
            $display("timeout with %0d bytes outstanding", expected_bytes.size());
            $display("[lzss_stream_encoder] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        wait (stim_done);
        wait (expected_bytes.size() == 0);
        repeat (500) @(posedge i_clk);
        $display("Sent %0d bytes in %0d streams; checked %0d packed bytes, %0d match tokens.",
                 items_sent, streams_sent, bytes_checked, matches_seen);
        if (errors == 0 && expected_bytes.size() == 0) begin
            $display("[lzss_stream_encoder] OK");
        end else begin
            $display("[lzss_stream_encoder] ERROR");
        end
        $finish;
    end

endmodule
